// ===== hdl/crc_gc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared types, constants and helper functions for the CRC generate/check unit.
// Depends on nothing; every other file takes its names by scope.
package crc_gc_pkg;

    localparam int MAX_DEGREE = 32;
    localparam int REM_W      = MAX_DEGREE;
    localparam int IDX_W      = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int CNT_W      = $clog2(MAX_DEGREE + 1);
    localparam int DEG_W      = 6;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TAPS   = 2'd0,
        CFG_DEGREE = 2'd1,
        CFG_MODE   = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        K_DATA    = 2'd0,
        K_VERDICT = 2'd1,
        K_BURST   = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               code;
        logic               pass;
        logic [REM_W-1:0]   rem;
        logic [CNT_W-1:0]   cnt;
    } t_cmd;

    function automatic logic [CNT_W-1:0] eff_degree(input logic [DEG_W-1:0] deg);
        logic [CNT_W-1:0] d;
        if (deg == '0) begin
            d = CNT_W'(1);
        end else if (int'(deg) > MAX_DEGREE) begin
            d = CNT_W'(MAX_DEGREE);
        end else begin
            d = CNT_W'(deg);
        end
        return d;
    endfunction

    function automatic logic [REM_W-1:0] deg_mask(input logic [CNT_W-1:0] d);
        logic [REM_W:0] m;
        m = ({{REM_W{1'b0}}, 1'b1} << d) - {{REM_W{1'b0}}, 1'b1};
        return m[REM_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== hdl/crc_gc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Front part: configuration registers, word acceptance and the serial remainder.
// Pushes one command per result group into the queue. Uses crc_gc_pkg.
module crc_gc_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [crc_gc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [crc_gc_pkg::CFG_W-1:0]  i_cfg_data,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_data_bit,
    input  wire logic                          i_last_bit,
    input  wire logic                          i_full,
    output logic                               o_push,
    output crc_gc_pkg::t_cmd                   o_cmd
);

    logic [crc_gc_pkg::REM_W-1:0] r_taps;
    logic [crc_gc_pkg::DEG_W-1:0] r_deg;
    logic                         r_mode;
    logic [crc_gc_pkg::REM_W-1:0] r_rem;
    logic [crc_gc_pkg::REM_W-1:0] n_rem;

    logic                         accept;
    logic [crc_gc_pkg::CNT_W-1:0] d;
    logic [crc_gc_pkg::IDX_W-1:0] top_idx;
    logic [crc_gc_pkg::REM_W-1:0] mask;
    logic [crc_gc_pkg::REM_W-1:0] taps;
    logic [crc_gc_pkg::REM_W-1:0] rem;
    logic [crc_gc_pkg::REM_W-1:0] shifted;
    logic [crc_gc_pkg::REM_W-1:0] rem_next;
    logic                         top;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taps <= '0;
            r_deg  <= crc_gc_pkg::DEG_W'(8);
            r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (crc_gc_pkg::t_cfg_idx'(i_cfg_index))
                crc_gc_pkg::CFG_TAPS:   r_taps <= i_cfg_data[crc_gc_pkg::REM_W-1:0];
                crc_gc_pkg::CFG_DEGREE: r_deg  <= i_cfg_data[crc_gc_pkg::DEG_W-1:0];
                crc_gc_pkg::CFG_MODE:   r_mode <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        d        = crc_gc_pkg::eff_degree(r_deg);
        top_idx  = crc_gc_pkg::IDX_W'(d - crc_gc_pkg::CNT_W'(1));
        mask     = crc_gc_pkg::deg_mask(d);
        taps     = r_taps & mask;
        rem      = r_rem & mask;
        top      = rem[top_idx];
        if (r_mode) begin
            shifted  = {rem[crc_gc_pkg::REM_W-2:0], i_data_bit} & mask;
            rem_next = top ? (shifted ^ taps) : shifted;
        end else begin
            shifted  = {rem[crc_gc_pkg::REM_W-2:0], 1'b0} & mask;
            rem_next = (top ^ i_data_bit) ? (shifted ^ taps) : shifted;
        end

        n_rem = r_rem;
        if (accept) begin
            n_rem = i_last_bit ? '0 : rem_next;
        end

        o_push     = accept && !(r_mode && !i_last_bit);
        o_cmd.code = r_mode ? 1'b0 : i_data_bit;
        o_cmd.pass = (rem_next == '0);
        o_cmd.rem  = rem_next;
        o_cmd.cnt  = d;
        if (r_mode) begin
            o_cmd.kind = crc_gc_pkg::K_VERDICT;
        end else if (i_last_bit) begin
            o_cmd.kind = crc_gc_pkg::K_BURST;
        end else begin
            o_cmd.kind = crc_gc_pkg::K_DATA;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else begin
            r_rem <= n_rem;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/crc_gc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Short command queue between the front and back parts.
// Holds crc_gc_pkg::t_cmd entries; uses crc_gc_pkg.
module crc_gc_queue (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire crc_gc_pkg::t_cmd i_cmd,
    output logic             o_full,
    input  wire logic        i_pop,
    output crc_gc_pkg::t_cmd o_cmd,
    output logic             o_empty
);

    crc_gc_pkg::t_cmd                r_mem [crc_gc_pkg::QDEPTH];
    logic [crc_gc_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [crc_gc_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [crc_gc_pkg::QPTR_W:0]     r_count;
    logic [crc_gc_pkg::QPTR_W-1:0]   n_wr_ptr;
    logic [crc_gc_pkg::QPTR_W-1:0]   n_rd_ptr;
    logic [crc_gc_pkg::QPTR_W:0]     n_count;
    logic                            do_push;
    logic                            do_pop;

    assign o_full  = (r_count == (crc_gc_pkg::QPTR_W+1)'(crc_gc_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + crc_gc_pkg::QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + crc_gc_pkg::QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + (crc_gc_pkg::QPTR_W+1)'(1);
        end else if (!do_push && do_pop) begin
            n_count = r_count - (crc_gc_pkg::QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/crc_gc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Back part: expands queued commands into result words, one per cycle
// unless stalled; remainder bits go out MSB first. Uses crc_gc_pkg.
module crc_gc_back (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire crc_gc_pkg::t_cmd i_cmd,
    input  wire logic        i_empty,
    output logic             o_pop,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_code_bit,
    output logic             o_is_remainder,
    output logic             o_check_passed,
    output logic             o_is_verdict,
    output logic             o_last_of_run
);

    logic                         r_valid;
    logic                         r_code;
    logic                         r_is_rem;
    logic                         r_pass;
    logic                         r_is_verd;
    logic                         r_last;
    logic [crc_gc_pkg::REM_W-1:0] r_burst;
    logic [crc_gc_pkg::CNT_W-1:0] r_cnt;

    logic                         n_valid;
    logic                         n_code;
    logic                         n_is_rem;
    logic                         n_pass;
    logic                         n_is_verd;
    logic                         n_last;
    logic [crc_gc_pkg::REM_W-1:0] n_burst;
    logic [crc_gc_pkg::CNT_W-1:0] n_cnt;

    logic                         take;
    logic                         in_burst;
    logic [crc_gc_pkg::CNT_W-1:0] cnt_m1;

    always_comb begin
        take      = !r_valid || !i_stall;
        in_burst  = (r_cnt != '0);
        cnt_m1    = r_cnt - crc_gc_pkg::CNT_W'(1);
        o_pop     = take && !in_burst && !i_empty;

        n_valid   = r_valid;
        n_code    = r_code;
        n_is_rem  = r_is_rem;
        n_pass    = r_pass;
        n_is_verd = r_is_verd;
        n_last    = r_last;
        n_burst   = r_burst;
        n_cnt     = r_cnt;

        if (take) begin
            n_valid   = 1'b0;
            n_code    = 1'b0;
            n_is_rem  = 1'b0;
            n_pass    = 1'b0;
            n_is_verd = 1'b0;
            n_last    = 1'b0;
            if (in_burst) begin
                n_valid  = 1'b1;
                n_code   = r_burst[cnt_m1[crc_gc_pkg::IDX_W-1:0]];
                n_is_rem = 1'b1;
                n_last   = (r_cnt == crc_gc_pkg::CNT_W'(1));
                n_cnt    = cnt_m1;
            end else if (!i_empty) begin
                n_valid = 1'b1;
                case (i_cmd.kind)
                    crc_gc_pkg::K_VERDICT: begin
                        n_pass    = i_cmd.pass;
                        n_is_verd = 1'b1;
                        n_last    = 1'b1;
                    end
                    crc_gc_pkg::K_BURST: begin
                        n_code  = i_cmd.code;
                        n_burst = i_cmd.rem;
                        n_cnt   = i_cmd.cnt;
                    end
                    default: begin
                        n_code = i_cmd.code;
                        n_last = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_valid <= n_valid;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code    <= n_code;
        r_is_rem  <= n_is_rem;
        r_pass    <= n_pass;
        r_is_verd <= n_is_verd;
        r_last    <= n_last;
        r_burst   <= n_burst;
    end

    assign o_valid        = r_valid;
    assign o_code_bit     = r_code;
    assign o_is_remainder = r_is_rem;
    assign o_check_passed = r_pass;
    assign o_is_verdict   = r_is_verd;
    assign o_last_of_run  = r_last;

endmodule
`default_nettype wire

// ===== hdl/crc_generate_and_check_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Top level of the bit-serial CRC generate/check unit with programmable polynomial.
// Instantiates crc_gc_front, crc_gc_queue and crc_gc_back; uses crc_gc_pkg.
//
// Input channel: i_valid / o_stall carry one data word (i_data_bit, i_last_bit).
// Output channel: o_valid / i_stall carry one result word per cycle unless stalled.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
//   (0 taps, 1 degree, 2 mode) at the clock edge; write only while idle.
// Throughput: one input word per cycle unless stalled. The remainder register in
//   the front part updates once per accepted bit. In generate mode a last bit
//   yields 1 + degree result words, shifted out by the back part one per cycle
//   unless i_stall is high, so the input stalls once the four-entry command queue
//   fills during that burst.
// Path: commands of accepted words go through the queue, then the output register.
// Receiver stall: the output register holds its word; the queue absorbs up
//   to four more commands, then o_stall rises until space frees.
// Reset (synchronous, active low): taps 0, degree 8, generate mode,
//   remainder cleared, queue emptied, output invalid.
module crc_generate_and_check_unit (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [crc_gc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [crc_gc_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic                             i_data_bit,
    input  wire logic                             i_last_bit,
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic                                  o_code_bit,
    output logic                                  o_is_remainder,
    output logic                                  o_check_passed,
    output logic                                  o_is_verdict,
    output logic                                  o_last_of_run
);

    logic             push;
    logic             pop;
    logic             full;
    logic             empty;
    crc_gc_pkg::t_cmd push_cmd;
    crc_gc_pkg::t_cmd head_cmd;

    crc_gc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_bit  (i_data_bit),
        .i_last_bit  (i_last_bit),
        .i_full      (full),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    crc_gc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (empty)
    );

    crc_gc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (head_cmd),
        .i_empty        (empty),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_code_bit     (o_code_bit),
        .o_is_remainder (o_is_remainder),
        .o_check_passed (o_check_passed),
        .o_is_verdict   (o_is_verdict),
        .o_last_of_run  (o_last_of_run)
    );

endmodule
`default_nettype wire

// ===== hdl/crc_gc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Port-level checker for the CRC generate/check unit, bound to the top level.
// Sees only the top-level ports; depends on crc_generate_and_check_unit.
module crc_gc_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_out_valid,
    input wire logic i_out_stall,
    input wire logic i_code_bit,
    input wire logic i_is_remainder,
    input wire logic i_check_passed,
    input wire logic i_is_verdict,
    input wire logic i_last_of_run
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_code_bit)
            && $stable(i_is_remainder) && $stable(i_last_of_run))
        else $error("stalled result word changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word valid after reset");

    a_kind_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_is_remainder && i_is_verdict))
        else $error("word is both remainder and verdict");

    a_verdict_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_is_verdict |-> i_last_of_run && !i_code_bit)
        else $error("verdict word malformed");

    a_pass_only_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_check_passed |-> i_is_verdict)
        else $error("pass flag outside verdict");

endmodule

bind crc_generate_and_check_unit crc_gc_checker u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_valid),
    .i_out_stall    (i_stall),
    .i_code_bit     (o_code_bit),
    .i_is_remainder (o_is_remainder),
    .i_check_passed (o_check_passed),
    .i_is_verdict   (o_is_verdict),
    .i_last_of_run  (o_last_of_run)
);
`default_nettype wire
